@@ sv/kns_pkg.sv @@
// ----------------------------------------------------------------------------
// kns_pkg
// Shared types, constants and helpers for the knitting needle selector.
// ----------------------------------------------------------------------------
package kns_pkg;

  localparam int PATTERN_NEEDLES_DEF = 200;
  localparam logic [15:0] REQUEST_TIMEOUT_RST = 16'd2000;

  // Field widths of the position and the pattern width
  localparam int POS_W = 16;
  localparam int WID_W = 9;

  // Modulo unit: quotient bits retired per cycle
  localparam int DIV_STEP = 4;
  localparam int DIV_CYC  = POS_W / DIV_STEP;
  localparam int DIV_CNT_W = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;

  typedef enum logic [2:0] {
    CMD_SENSOR = 3'd0,
    CMD_START  = 3'd1,
    CMD_BYTE   = 3'd2,
    CMD_DONE   = 3'd3,
    CMD_TICK   = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    MODE_START     = 3'd1,
    MODE_REQUEST   = 3'd2,
    MODE_REQUESTED = 3'd3,
    MODE_KNIT      = 3'd4,
    MODE_LAST      = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOOKUP,
    ST_DONE
  } state_t;

  function automatic logic [POS_W-1:0] step_pos(input logic [POS_W-1:0] p,
                                                input logic right);
    return right ? p + POS_W'(1) : p - POS_W'(1);
  endfunction

endpackage

@@ sv/kns_modulo.sv @@
// ----------------------------------------------------------------------------
// kns_modulo
// Iterative unsigned remainder: position magnitude mod pattern width.
// ----------------------------------------------------------------------------
module kns_modulo
  import kns_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [POS_W-1:0] dividend,
  input  logic [WID_W-1:0] divisor,
  output logic             done,
  output logic [WID_W-1:0] remainder
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [POS_W-1:0]     dvd;
  logic [POS_W-1:0]     dvd_next;
  logic [WID_W-1:0]     dsr;
  logic [WID_W-1:0]     rem_next;

  // Restoring steps, DIV_STEP bits per cycle
  always_comb begin
    logic [WID_W:0]   t;
    logic [WID_W-1:0] r;
    logic [POS_W-1:0] d;
    r = remainder;
    d = dvd;
    t = '0;
    for (int i = 0; i < DIV_STEP; i++) begin
      t = {r, d[POS_W-1]};
      d = {d[POS_W-2:0], 1'b0};
      if (t >= {1'b0, dsr}) begin
        t = t - {1'b0, dsr};
      end
      r = t[WID_W-1:0];
    end
    rem_next = r;
    dvd_next = d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(DIV_CYC - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd       <= dividend;
      dsr       <= divisor;
      remainder <= '0;
    end else if (busy) begin
      dvd       <= dvd_next;
      remainder <= rem_next;
    end
  end

endmodule

@@ sv/kns_pattern_mem.sv @@
// ----------------------------------------------------------------------------
// kns_pattern_mem
// Row pattern byte store with registered read and per-byte valid bits.
// ----------------------------------------------------------------------------
module kns_pattern_mem
  import kns_pkg::*;
#(
  parameter int BYTES = (PATTERN_NEEDLES_DEF + 7) / 8,
  parameter int AW    = (BYTES > 1) ? $clog2(BYTES) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0]       mem [BYTES];
  logic [BYTES-1:0] valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= valid[rd_addr] ? mem[rd_addr] : 8'd0;
    end
  end

  // Unwritten bytes read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

endmodule

@@ sv/knitting_needle_selector.sv @@
// ----------------------------------------------------------------------------
// knitting_needle_selector
// Carriage tracker and solenoid driver with a byte-wide row pattern store.
// ----------------------------------------------------------------------------
// Flow: an accepted item goes from ST_IDLE to ST_DONE, which loads m_tvalid,
//   when no pattern lookup is needed; a rising clock-pin sample inside the cams
//   while knitting passes through ST_DIV (modulo, done flag) and ST_LOOKUP (one
//   memory read), or skips ST_LOOKUP when the pattern bit lies past the buffer.
//   A new item is taken only back in ST_IDLE; a stalled output holds the input.
// Reset: synchronous, active high; unwritten pattern bytes read as zero.
module knitting_needle_selector
  import kns_pkg::*;
#(
  parameter int PATTERN_NEEDLES = PATTERN_NEEDLES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // tuser: cmd[2:0]
  // tdata: moving_right[0], inside_cams[1], at_needle_one[2], clock_level[3],
  //        first_needle[11:4], last_needle[19:12], byte_index[24:20],
  //        byte_value[32:25], final_row[33], zero fill[39:34]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [2:0]  s_tuser,
  input  logic [39:0] s_tdata,
  // tdata: solenoid[0], waiting_led[1], row_request[2], row_number[10:3],
  //        zero fill[15:11]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,
  // request_timeout write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int PAT_BYTES = (PATTERN_NEEDLES + 7) / 8;
  localparam int AW        = (PAT_BYTES > 1) ? $clog2(PAT_BYTES) : 1;

  // Input field unpacking
  logic       moving_right;
  logic       inside_cams;
  logic       at_needle_one;
  logic       clock_level;
  logic [7:0] first_needle;
  logic [7:0] last_needle;
  logic [4:0] byte_index;
  logic [7:0] byte_value;
  logic       final_row;
  cmd_t       cmd;

  assign cmd           = cmd_t'(s_tuser);
  assign moving_right  = s_tdata[0];
  assign inside_cams   = s_tdata[1];
  assign at_needle_one = s_tdata[2];
  assign clock_level   = s_tdata[3];
  assign first_needle  = s_tdata[11:4];
  assign last_needle   = s_tdata[19:12];
  assign byte_index    = s_tdata[24:20];
  assign byte_value    = s_tdata[32:25];
  assign final_row     = s_tdata[33];

  // Tracker state
  logic [15:0]      request_timeout;
  mode_t            mode,           mode_next;
  logic [7:0]       row_count,      row_count_next;
  logic [7:0]       pat_offset,     pat_offset_next;
  logic [WID_W-1:0] pat_width,      pat_width_next;
  logic [POS_W-1:0] needle_pos,     needle_pos_next;
  logic             was_inside,     was_inside_next;
  logic             prev_clock,     prev_clock_next;
  logic             needle_one_seen, needle_one_seen_next;
  logic [15:0]      wait_ticks,     wait_ticks_next;
  logic             solenoid_level, solenoid_level_next;

  // Result fields held until the solenoid is known
  logic       res_led,  res_led_next;
  logic       res_req,  res_req_next;
  logic [7:0] res_row,  res_row_next;

  // Lookup path
  logic             pos_neg;
  logic [2:0]       bit_sel;
  logic             need_select;
  logic             accept;
  logic             div_done;
  logic [WID_W-1:0] div_rem;
  logic [WID_W-1:0] rem_adj;
  logic [WID_W:0]   bit_index;
  logic             bit_in_range;
  logic [7:0]       rd_data;
  logic             div_start;
  logic             rd_en;
  logic             load_out;
  logic             pat_wr;
  logic [15:0]      tick_count;

  state_t state, state_next;

  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign pat_wr    = accept && (cmd == CMD_BYTE) &&
                     ({1'b0, byte_index} < 6'(PAT_BYTES));
  assign tick_count = (wait_ticks == 16'hFFFF) ? wait_ticks : wait_ticks + 16'd1;

  // Apply one item to the tracker state; solenoid is resolved later when a
  // pattern lookup is needed.
  always_comb begin
    logic [POS_W-1:0] pos_t;
    logic             issue;
    mode_next            = mode;
    row_count_next       = row_count;
    pat_offset_next      = pat_offset;
    pat_width_next       = pat_width;
    needle_pos_next      = needle_pos;
    was_inside_next      = was_inside;
    prev_clock_next      = prev_clock;
    needle_one_seen_next = needle_one_seen;
    wait_ticks_next      = wait_ticks;
    solenoid_level_next  = solenoid_level;
    need_select          = 1'b0;
    issue                = 1'b0;
    pos_t                = needle_pos;
    unique case (cmd)
      CMD_SENSOR: begin
        prev_clock_next = clock_level;
        if (clock_level && !prev_clock) begin
          // Leaving the cams ends a row pass
          if (was_inside != inside_cams) begin
            if (was_inside) begin
              if (mode == MODE_KNIT) begin
                row_count_next = row_count + 8'd1;
                mode_next      = MODE_REQUEST;
              end else if (mode == MODE_LAST) begin
                mode_next            = MODE_START;
                needle_one_seen_next = 1'b0;
              end
              pos_t = step_pos(pos_t, moving_right);
            end
            was_inside_next = inside_cams;
          end
          solenoid_level_next = 1'b0;
          if (inside_cams) begin
            pos_t = step_pos(pos_t, moving_right);
            // First right-moving pass over the marker zeroes the position
            if (at_needle_one && !needle_one_seen && moving_right) begin
              pos_t                = '0;
              needle_one_seen_next = 1'b1;
            end
            need_select = ((mode == MODE_KNIT) || (mode == MODE_LAST)) &&
                          (pat_width != '0);
          end
          needle_pos_next = pos_t;
        end
      end
      CMD_START: begin
        pat_offset_next = first_needle;
        pat_width_next  = (last_needle >= first_needle) ?
                          ({1'b0, last_needle} - {1'b0, first_needle} + WID_W'(1)) :
                          '0;
        row_count_next  = '0;
        mode_next       = MODE_REQUEST;
      end
      CMD_BYTE: begin
      end
      CMD_DONE: begin
        mode_next = final_row ? MODE_LAST : MODE_KNIT;
      end
      CMD_TICK: begin
        if (mode == MODE_REQUESTED) begin
          wait_ticks_next = tick_count;
          issue           = tick_count > request_timeout;
        end
      end
      default: begin
      end
    endcase
    if (mode_next == MODE_REQUEST) begin
      issue = 1'b1;
    end
    if (issue) begin
      mode_next       = MODE_REQUESTED;
      wait_ticks_next = '0;
    end
    res_led_next = (mode_next == MODE_REQUEST) || (mode_next == MODE_REQUESTED);
    res_req_next = issue;
    res_row_next = issue ? row_count_next : 8'd0;
  end

  // Fold the signed position back into [0, width) and add the start offset
  assign rem_adj      = (pos_neg && (div_rem != '0)) ? pat_width - div_rem : div_rem;
  assign bit_index    = {1'b0, rem_adj} + {2'b0, pat_offset};
  assign bit_in_range = bit_index < (WID_W + 1)'(PATTERN_NEEDLES);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = need_select ? ST_DIV : ST_DONE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = bit_in_range ? ST_LOOKUP : ST_DONE;
        end
      end
      ST_LOOKUP: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // FSM outputs
  always_comb begin
    s_tready  = (state == ST_IDLE);
    div_start = (state == ST_IDLE) && s_tvalid && need_select;
    rd_en     = (state == ST_DIV) && div_done && bit_in_range;
    load_out  = (state == ST_DONE) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      request_timeout <= REQUEST_TIMEOUT_RST;
      mode            <= MODE_START;
      row_count       <= '0;
      pat_offset      <= '0;
      pat_width       <= '0;
      needle_pos      <= '0;
      was_inside      <= 1'b0;
      prev_clock      <= 1'b0;
      needle_one_seen <= 1'b0;
      wait_ticks      <= '0;
      solenoid_level  <= 1'b0;
      m_tvalid        <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        request_timeout <= cfg_data;
      end
      if (accept) begin
        mode            <= mode_next;
        row_count       <= row_count_next;
        pat_offset      <= pat_offset_next;
        pat_width       <= pat_width_next;
        needle_pos      <= needle_pos_next;
        was_inside      <= was_inside_next;
        prev_clock      <= prev_clock_next;
        needle_one_seen <= needle_one_seen_next;
        wait_ticks      <= wait_ticks_next;
        solenoid_level  <= solenoid_level_next;
      end else if (state == ST_LOOKUP) begin
        solenoid_level <= rd_data[bit_sel];
      end
      // Drop the output once taken, refill from the finished item
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      res_led <= res_led_next;
      res_req <= res_req_next;
      res_row <= res_row_next;
      pos_neg <= needle_pos_next[POS_W-1];
    end
    if (rd_en) begin
      bit_sel <= bit_index[2:0];
    end
    if (load_out) begin
      m_tdata <= {5'd0, res_row, res_req, res_led, solenoid_level};
    end
  end

  kns_modulo u_modulo (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (needle_pos_next[POS_W-1] ? -needle_pos_next : needle_pos_next),
    .divisor   (pat_width),
    .done      (div_done),
    .remainder (div_rem)
  );

  kns_pattern_mem #(
    .BYTES (PAT_BYTES),
    .AW    (AW)
  ) u_pattern_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (pat_wr),
    .wr_addr (byte_index[AW-1:0]),
    .wr_data (byte_value),
    .rd_en   (rd_en),
    .rd_addr (bit_index[AW+2:3]),
    .rd_data (rd_data)
  );

`ifndef SYNTHESIS
  // A lookup only follows a finished modulo
  a_lookup_after_div: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOKUP) |-> ($past(state) == ST_DIV))
    else $error("pattern lookup without modulo");

  // Modulo completes only while the FSM waits for it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("modulo done outside wait state");

  // A row request always shows the waiting LED
  a_request_led: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2]) |-> m_tdata[1])
    else $error("row request without waiting led");

  // Row number is zero unless a request is issued
  a_row_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[2]) |-> (m_tdata[10:3] == 8'd0))
    else $error("row number without request");
`endif

endmodule
